// File: rtl/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_DELAY   = 2'd1;
  localparam logic [1:0] ACT_RESCHED = 2'd2;

  localparam int unsigned TickWidth = 32;
  localparam int unsigned MaskWidth = 8;
  localparam int unsigned TaskIdWidth = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL_READ,
    ST_REL_CHECK,
    ST_DELAY,
    ST_PICK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic rel_init;
    logic rel_check;
    logic block_run;
    logic pick_init;
    logic pick_step;
    logic pick_take;
    logic pick_idle;
    logic set_sw;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic run_idle;
    logic rel_last;
    logic pick_hit;
    logic pick_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl import rrts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (action)
            ACT_RELEASE: begin
              cmd.rel_init = 1'b1;
              state_next   = ST_REL_READ;
            end
            ACT_DELAY: begin
              state_next = stat.run_idle ? ST_DONE : ST_DELAY;
            end
            ACT_RESCHED: begin
              cmd.pick_init = 1'b1;
              cmd.set_sw    = 1'b1;
              state_next    = ST_PICK;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_REL_READ: begin
        state_next = ST_REL_CHECK;
      end
      ST_REL_CHECK: begin
        cmd.rel_check = 1'b1;
        state_next    = stat.rel_last ? ST_DONE : ST_REL_READ;
      end
      ST_DELAY: begin
        cmd.block_run = 1'b1;
        cmd.pick_init = 1'b1;
        cmd.set_sw    = 1'b1;
        state_next    = ST_PICK;
      end
      ST_PICK: begin
        if (stat.pick_hit) begin
          cmd.pick_take = 1'b1;
          state_next    = ST_DONE;
        end else if (stat.pick_last) begin
          cmd.pick_idle = 1'b1;
          state_next    = ST_DONE;
        end else begin
          cmd.pick_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rrts_dp.sv
`default_nettype none

module rrts_dp import rrts_pkg::*; #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [TickWidth-1:0]   now_tick,
  input  logic [TickWidth-1:0]   delay_ticks,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TaskIdWidth-1:0] current_task,
  output logic [MaskWidth-1:0]   ready_mask,
  output logic                   switch_needed
);

  localparam int unsigned TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [TW-1:0] LastTask = TW'(TASK_COUNT - 1);

  logic [TickWidth-1:0] wake [TASK_COUNT];
  logic [TickWidth-1:0] rd_data;
  logic [TickWidth-1:0] now_r;
  logic [TickWidth-1:0] delay_r;
  logic [TASK_COUNT-1:0] blocked;
  logic [TW-1:0]        running;
  logic [TW-1:0]        idx;
  logic [TW-1:0]        cand;
  logic [TW-1:0]        cnt;
  logic                 sw;
  logic [31:0]          run_ext;
  logic [MaskWidth-1:0] mask_now;

  always_ff @(posedge clk) begin
    if (cmd.block_run) begin
      wake[running] <= now_r + delay_r;
    end
    rd_data <= wake[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r   <= now_tick;
      delay_r <= delay_ticks;
    end
    if (cmd.rel_init) begin
      idx <= TW'(1);
    end else if (cmd.rel_check) begin
      idx <= idx + TW'(1);
    end
    if (cmd.pick_init) begin
      cand <= (running == LastTask) ? '0 : running + TW'(1);
      cnt  <= '0;
    end else if (cmd.pick_step) begin
      cand <= (cand == LastTask) ? '0 : cand + TW'(1);
      cnt  <= cnt + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked   <= '0;
      running   <= '0;
      sw        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.rel_check && blocked[idx] && (rd_data <= now_r)) begin
        blocked[idx] <= 1'b0;
      end
      if (cmd.block_run) begin
        blocked[running] <= 1'b1;
      end
      if (cmd.pick_take) begin
        running <= cand;
      end else if (cmd.pick_idle) begin
        running <= '0;
      end
      if (cmd.set_sw) begin
        sw <= 1'b1;
      end else if (cmd.capture) begin
        sw <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign run_ext = 32'(running);

  for (genvar i = 0; i < MaskWidth; i++) begin : g_mask
    if (i < TASK_COUNT) begin : g_task
      assign mask_now[i] = ~blocked[i];
    end else begin : g_none
      assign mask_now[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      current_task  <= run_ext[TaskIdWidth-1:0];
      ready_mask    <= mask_now;
      switch_needed <= sw;
    end
  end

  always_comb begin
    stat.run_idle  = (running == '0);
    stat.rel_last  = (idx == LastTask);
    stat.pick_hit  = (cand != '0) && !blocked[cand];
    stat.pick_last = (cnt == LastTask);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// File: rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler with task 0 as the idle task. One result follows every input
// transfer. In a release, each task other than task 0 costs one wake-tick memory read and
// one compare. In a reschedule, and in a delay of any task but the idle task, the selection
// scan examines one candidate task per cycle. The next item is taken as soon as the result
// sits in the output register, even while that result waits to be taken. Wake ticks compare
// as plain unsigned values, with no wrap.
`default_nettype none

module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [TickWidth-1:0]   now_tick,
  input  logic [TickWidth-1:0]   delay_ticks,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TaskIdWidth-1:0] current_task,
  output logic [MaskWidth-1:0]   ready_mask,
  output logic                   switch_needed
);

  cmd_t  cmd;
  stat_t stat;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dp #(
    .TASK_COUNT (TASK_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .now_tick      (now_tick),
    .delay_ticks   (delay_ticks),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .current_task  (current_task),
    .ready_mask    (ready_mask),
    .switch_needed (switch_needed)
  );

endmodule

`default_nettype wire

// File: rtl/rrts_chk.sv
`default_nettype none

module rrts_chk import rrts_pkg::*; #(
  parameter int unsigned TASK_COUNT = 8
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [TaskIdWidth-1:0] current_task,
  input wire logic [MaskWidth-1:0]   ready_mask,
  input wire logic                   switch_needed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_task)
      && $stable(ready_mask) && $stable(switch_needed))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ready_mask[0])
    else $error("idle task shown blocked");

  a_current_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && (TASK_COUNT <= MaskWidth) |-> ready_mask[current_task])
    else $error("selected task is blocked");

endmodule

bind round_robin_task_scheduler rrts_chk #(
  .TASK_COUNT (TASK_COUNT)
) u_rrts_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .current_task  (current_task),
  .ready_mask    (ready_mask),
  .switch_needed (switch_needed)
);

`default_nettype wire
